[hdl/swt_pkg.sv]
// shared types and constants for the scoreboard wait tracker
package swt_pkg;
    localparam int REG_UNITS     = 256;
    localparam int SLOT_COUNT    = 4;
    localparam int PENDING_LIMIT = 8;
    localparam int FRAME_DEPTH   = 64;
    localparam int FRAME_BITS    = 6;

    localparam logic [2:0] MODE_INSTR = 3'd0;
    localparam logic [2:0] MODE_END   = 3'd1;
    localparam logic [2:0] MODE_OPEN  = 3'd2;
    localparam logic [2:0] MODE_ELSE  = 3'd3;
    localparam logic [2:0] MODE_MERGE = 3'd4;

    typedef logic [255:0] map_t;
    typedef logic [3:0]   cnt_t;

    // one frame image: four maps and four counts
    typedef struct packed {
        map_t [3:0] maps;
        cnt_t [3:0] cnts;
    } frame_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DONE
    } state_t;

    // registered lane findings passed to the merging stage
    typedef struct packed {
        logic [3:0] hit;
        logic [3:0] busy;
    } lane_stat_t;

    // unit mask for a base and a size, units at or past REG_UNITS dropped
    function automatic map_t range_mask(input logic [7:0] base, input logic [3:0] cnt);
        map_t m;
        logic [8:0] r;
        m = '0;
        for (int i = 0; i < 15; i++)
        begin
            r = {1'b0, base} + 9'(i);
            if ((4'(i) < cnt) && (r < 9'(REG_UNITS)) && !r[8])
                m[r[7:0]] = 1'b1;
        end
        return m;
    endfunction
endpackage

[hdl/swt_lane.sv]
// one slot lane: hazard check of an item's ranges against the slot map, and whether the slot has pending work
module swt_lane (
    input  logic           clk,
    input  swt_pkg::map_t  slot_map,
    input  swt_pkg::cnt_t  slot_cnt,
    input  swt_pkg::map_t  use_mask,
    output logic           hit,
    output logic           busy
);
    logic hit_reg;
    logic busy_reg;

    always_ff @(posedge clk)
    begin
        hit_reg  <= |(slot_map & use_mask);
        busy_reg <= (slot_cnt != '0);
    end

    assign hit  = hit_reg;
    assign busy = busy_reg;
endmodule

[hdl/swt_frame_ram.sv]
// frame stack memory, one frame image per word
module swt_frame_ram (
    input  logic                            clk,
    input  logic                            we,
    input  logic [swt_pkg::FRAME_BITS-1:0]  waddr,
    input  swt_pkg::frame_t                 wdata,
    input  logic [swt_pkg::FRAME_BITS-1:0]  raddr,
    output swt_pkg::frame_t                 rdata
);
    swt_pkg::frame_t mem [swt_pkg::FRAME_DEPTH];
    swt_pkg::frame_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[hdl/scoreboard_wait_tracker.sv]
// top level of the scoreboard wait tracker
// usage:
//   drive an item on the input ports with start high; it is taken at a rising
//   edge where busy is low. one result per item comes back with done high for
//   exactly one cycle, carrying stall_mask, assigned_slot and region_accepted.
// sequence:
//   busy stays high through the read and done states of an item, for every
//   mode alike, so the next item is taken only once done has fallen.
//   the accept edge registers the four lane hazard checks and the frame memory
//   reads; the next cycle merges lane findings and updates the slots and frame
//   stack; the result registers drive the last cycle.
// reset:
//   rst_n clears slot maps, pending counts, the frame depth and control state.
//   frame memory contents are not cleared; a frame is fully written on push.
// the receiver cannot stall: results are shown for one cycle only.
module scoreboard_wait_tracker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output logic       done,
    input  logic [2:0] mode,
    input  logic [7:0] src0_reg,
    input  logic [3:0] src0_count,
    input  logic [7:0] src1_reg,
    input  logic [3:0] src1_count,
    input  logic [7:0] src2_reg,
    input  logic [3:0] src2_count,
    input  logic [7:0] dst_reg,
    input  logic [3:0] dst_count,
    input  logic       is_async,
    input  logic       is_barrier,
    input  logic       carry_or_fold,
    output logic [3:0] stall_mask,
    output logic [1:0] assigned_slot,
    output logic       region_accepted
);
    swt_pkg::state_t state_reg, state_next;

    // captured item
    logic [2:0]    mode_reg;
    logic          async_reg, barrier_reg, carry_reg;
    swt_pkg::map_t dst_mask_reg;
    swt_pkg::map_t use_mask;

    // slot state
    swt_pkg::map_t [3:0] map_reg, map_next;
    swt_pkg::cnt_t [3:0] cnt_reg, cnt_next;
    logic [6:0] depth_reg, depth_next;

    // result registers
    logic [3:0] mask_reg, mask_next;
    logic [1:0] slot_reg, slot_next;
    logic       acc_reg, acc_next;

    // frame memories: entry and then images
    logic                           ent_we, thn_we;
    swt_pkg::frame_t                ent_wdata, thn_wdata, ent_rdata, thn_rdata;
    logic [swt_pkg::FRAME_BITS-1:0] top_idx, push_idx;

    swt_pkg::lane_stat_t lane_stat;

    logic accept;
    assign accept = start && (state_reg == swt_pkg::ST_IDLE);

    assign use_mask = swt_pkg::range_mask(src0_reg, src0_count)
                    | swt_pkg::range_mask(src1_reg, src1_count)
                    | swt_pkg::range_mask(src2_reg, src2_count)
                    | swt_pkg::range_mask(dst_reg, dst_count);

    // lanes check all slots side by side in the accept cycle
    for (genvar s = 0; s < swt_pkg::SLOT_COUNT; s++)
    begin : g_lane
        swt_lane u_lane (
            .clk      (clk),
            .slot_map (map_reg[s]),
            .slot_cnt (cnt_reg[s]),
            .use_mask (use_mask),
            .hit      (lane_stat.hit[s]),
            .busy     (lane_stat.busy[s])
        );
    end
    for (genvar s = swt_pkg::SLOT_COUNT; s < 4; s++)
    begin : g_nolane
        assign lane_stat.hit[s]  = 1'b0;
        assign lane_stat.busy[s] = 1'b0;
    end

    assign top_idx  = swt_pkg::FRAME_BITS'(depth_reg - 7'd1);
    assign push_idx = swt_pkg::FRAME_BITS'(depth_reg);

    swt_frame_ram u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (push_idx),
        .wdata (ent_wdata),
        .raddr (top_idx),
        .rdata (ent_rdata)
    );

    swt_frame_ram u_thn_ram (
        .clk   (clk),
        .we    (thn_we),
        .waddr (thn_we && (mode_reg == swt_pkg::MODE_OPEN) ? push_idx : top_idx),
        .wdata (thn_wdata),
        .raddr (top_idx),
        .rdata (thn_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swt_pkg::ST_IDLE;
            map_reg   <= '0;
            cnt_reg   <= '0;
            depth_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            map_reg   <= map_next;
            cnt_reg   <= cnt_next;
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg     <= mode;
            async_reg    <= is_async;
            barrier_reg  <= is_barrier;
            carry_reg    <= carry_or_fold;
            dst_mask_reg <= swt_pkg::range_mask(dst_reg, dst_count);
        end
        mask_reg <= mask_next;
        slot_reg <= slot_next;
        acc_reg  <= acc_next;
    end

    // next state
    always_comb
    begin
        case (state_reg)
            swt_pkg::ST_IDLE: state_next = accept ? swt_pkg::ST_READ : swt_pkg::ST_IDLE;
            swt_pkg::ST_READ: state_next = swt_pkg::ST_DONE;
            swt_pkg::ST_DONE: state_next = swt_pkg::ST_IDLE;
            default:          state_next = swt_pkg::ST_IDLE;
        endcase
    end

    // merging stage and state update
    always_comb
    begin
        logic [3:0]   m;
        logic [1:0]   a;
        logic         found;
        logic         stack_ok;
        swt_pkg::frame_t cur;
        map_next   = map_reg;
        cnt_next   = cnt_reg;
        depth_next = depth_reg;
        mask_next  = mask_reg;
        slot_next  = slot_reg;
        acc_next   = acc_reg;
        ent_we     = 1'b0;
        thn_we     = 1'b0;
        cur.maps   = map_reg;
        cur.cnts   = cnt_reg;
        ent_wdata  = cur;
        thn_wdata  = cur;
        m     = '0;
        a     = '0;
        found = 1'b0;
        stack_ok = (depth_reg != '0) && (depth_reg <= 7'(swt_pkg::FRAME_DEPTH));
        if (state_reg == swt_pkg::ST_READ)
        begin
            acc_next = 1'b0;
            case (mode_reg)
                swt_pkg::MODE_INSTR:
                begin
                    m = lane_stat.hit | (barrier_reg ? lane_stat.busy : 4'b0);
                    if (async_reg)
                    begin
                        for (int s = 0; s < swt_pkg::SLOT_COUNT; s++)
                        begin
                            if (!found && !lane_stat.busy[s])
                            begin
                                a = 2'(s);
                                found = 1'b1;
                            end
                        end
                        if (cnt_reg[a] >= 4'(swt_pkg::PENDING_LIMIT))
                            m[a] = 1'b1;
                    end
                    for (int s = 0; s < 4; s++)
                    begin
                        if (m[s])
                        begin
                            map_next[s] = '0;
                            cnt_next[s] = '0;
                        end
                    end
                    if (async_reg)
                    begin
                        map_next[a] = map_next[a] | dst_mask_reg;
                        cnt_next[a] = cnt_next[a] + 4'd1;
                    end
                end
                swt_pkg::MODE_END:
                begin
                    if (!carry_reg)
                    begin
                        m = lane_stat.busy;
                        for (int s = 0; s < 4; s++)
                        begin
                            if (m[s])
                            begin
                                map_next[s] = '0;
                                cnt_next[s] = '0;
                            end
                        end
                    end
                end
                swt_pkg::MODE_OPEN:
                begin
                    if (depth_reg < 7'(swt_pkg::FRAME_DEPTH))
                    begin
                        ent_we     = 1'b1;
                        thn_we     = 1'b1;
                        thn_wdata  = '0;
                        depth_next = depth_reg + 7'd1;
                        acc_next   = 1'b1;
                    end
                end
                swt_pkg::MODE_ELSE:
                begin
                    if (stack_ok)
                    begin
                        thn_we   = 1'b1;
                        map_next = ent_rdata.maps;
                        cnt_next = ent_rdata.cnts;
                        if (carry_reg)
                        begin
                            for (int s = 0; s < 4; s++)
                            begin
                                map_next[s] = ent_rdata.maps[s] | map_reg[s];
                                cnt_next[s] = (cnt_reg[s] > ent_rdata.cnts[s]) ?
                                              cnt_reg[s] : ent_rdata.cnts[s];
                            end
                            depth_next = depth_reg - 7'd1;
                        end
                    end
                end
                swt_pkg::MODE_MERGE:
                begin
                    if (stack_ok)
                    begin
                        for (int s = 0; s < 4; s++)
                        begin
                            map_next[s] = map_reg[s] | thn_rdata.maps[s];
                            cnt_next[s] = (thn_rdata.cnts[s] > cnt_reg[s]) ?
                                          thn_rdata.cnts[s] : cnt_reg[s];
                        end
                        depth_next = depth_reg - 7'd1;
                    end
                end
                default:
                begin
                    m = '0;
                end
            endcase
            mask_next = m;
            slot_next = a;
        end
    end

    // outputs
    always_comb
    begin
        busy = (state_reg != swt_pkg::ST_IDLE);
        done = (state_reg == swt_pkg::ST_DONE);
    end

    assign stall_mask      = mask_reg;
    assign assigned_slot   = slot_reg;
    assign region_accepted = acc_reg;

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= 7'(swt_pkg::FRAME_DEPTH)) else $error("frame depth overflow");
    a_acc_mask: assert property (@(posedge clk) disable iff (!rst_n)
        done && region_accepted |-> stall_mask == '0) else $error("bad result");
    a_read_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == swt_pkg::ST_READ) else $error("sequence slip");
endmodule
